// ----- hdl/lzfd_pkg.sv -----
`default_nettype none

package lzfd_pkg;

  // History window and the counters that walk it.
  localparam int unsigned WINDOW_DEPTH = 8192;
  localparam int unsigned ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int unsigned PROD_W       = ADDR_W + 1;

  // Output packing.
  localparam int unsigned PACK_BYTES   = 8;
  localparam int unsigned FILL_W       = $clog2(PACK_BYTES + 1);
  localparam int unsigned PACK_IDX_W   = (PACK_BYTES > 1) ? $clog2(PACK_BYTES) : 1;

  // Token fields.
  localparam int unsigned LEN_W        = 9;   // count + 2, up to 257
  localparam int unsigned DIST_W       = 14;  // copy distance, up to 8192
  localparam logic [DIST_W-1:0] LONG_BASE  = 14'h2000;
  localparam logic [DIST_W-1:0] SHORT_BASE = 14'h0100;
  localparam logic [2:0]        TOKEN_COUNT_MASK = 3'd7;
  localparam logic [4:0]        FLAG_WORD_BITS   = 5'd16;

  typedef enum logic [3:0] {
    PH_TOP,
    PH_SECOND,
    PH_C1,
    PH_C2,
    PH_LIT,
    PH_TOK_LO,
    PH_TOK_HI,
    PH_CNT,
    PH_SOFF
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_END  = 2'd1,
    ST_FAR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RESTART,
    CMD_LIT,
    CMD_COPY,
    CMD_END
  } cmd_op_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_COPY,
    ENG_EMIT
  } eng_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    status_t     status;
  } result_t;

  // Work handed from the token parser to the copy engine.
  typedef struct packed {
    cmd_op_t           op;
    logic [7:0]        data;
    logic [7:0]        count;
    logic [DIST_W-1:0] distance;
  } cmd_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] word;
    logic [4:0]  left;
    logic [7:0]  count;
  } adv_t;

  // Consumes flag bits until a byte is needed or the flag word runs dry.
  // At most four bits go in one call.
  function automatic adv_t flag_advance(phase_t ph_in, logic [15:0] word_in,
                                        logic [4:0] left_in, logic [7:0] count_in);
    adv_t a;
    logic bitv;
    a.phase = ph_in;
    a.word  = word_in;
    a.left  = left_in;
    a.count = count_in;
    for (int i = 0; i < 4; i++) begin
      if (a.left != 5'd0 && (a.phase inside {PH_TOP, PH_SECOND, PH_C1, PH_C2})) begin
        bitv   = a.word[0];
        a.word = a.word >> 1;
        a.left = a.left - 5'd1;
        case (a.phase)
          PH_TOP:    a.phase = bitv ? PH_LIT : PH_SECOND;
          PH_SECOND: a.phase = bitv ? PH_TOK_LO : PH_C1;
          PH_C1: begin
            a.count = {6'b0, bitv, 1'b0};
            a.phase = PH_C2;
          end
          default: begin
            a.count = a.count | {7'b0, bitv};
            a.phase = PH_SOFF;
          end
        endcase
      end
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/lzfd_hist_ram.sv -----
`default_nettype none

module lzfd_hist_ram
  import lzfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [WINDOW_DEPTH];
  logic [7:0] rd_q;
  logic       byp;
  logic [7:0] byp_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // A read that meets a write to the same entry returns the new byte.
  always_ff @(posedge clk) begin
    byp      <= we && (waddr == raddr);
    byp_data <= wdata;
  end

  assign rdata = byp ? byp_data : rd_q;

endmodule

`default_nettype wire

// ----- hdl/lzfd_parser.sv -----
`default_nettype none

module lzfd_parser
  import lzfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  input  wire item_t item,
  input  wire logic  cmd_ready,
  output cmd_t       cmd
);

  phase_t            phase, phase_next;
  logic [15:0]       flag_word, flag_word_next;
  logic [4:0]        bits_left, bits_left_next;
  logic              flag_half, flag_half_next;
  logic [7:0]        token_low, token_low_next;
  logic [7:0]        match_count, match_count_next;
  logic [DIST_W-1:0] match_offset, match_offset_next;

  logic [7:0]        b;
  logic [15:0]       tok;
  logic [DIST_W-1:0] long_dist;
  logic [DIST_W-1:0] short_dist;
  adv_t              adv;

  assign b          = item.in_byte;
  assign tok        = {b, token_low};
  assign long_dist  = LONG_BASE - {1'b0, tok[15:3]};
  assign short_dist = SHORT_BASE - {6'b0, b};

  always_comb begin
    phase_t      ph;
    logic [15:0] fw;
    logic [4:0]  lf;
    logic [7:0]  cn;
    ph = phase;
    fw = flag_word;
    lf = bits_left;
    cn = match_count;
    flag_half_next    = flag_half;
    token_low_next    = token_low;
    match_offset_next = match_offset;
    cmd.op       = CMD_NONE;
    cmd.data     = b;
    cmd.count    = match_count;
    cmd.distance = match_offset;

    if (item.kind) begin
      cmd.op            = CMD_RESTART;
      ph                = PH_TOP;
      fw                = '0;
      lf                = '0;
      cn                = '0;
      flag_half_next    = 1'b0;
      token_low_next    = '0;
      match_offset_next = '0;
    end else begin
      case (phase)
        PH_TOP, PH_SECOND, PH_C1, PH_C2: begin
          if (!flag_half) begin
            fw             = {8'h00, b};
            flag_half_next = 1'b1;
          end else begin
            fw             = {b, flag_word[7:0]};
            flag_half_next = 1'b0;
            lf             = FLAG_WORD_BITS;
          end
        end
        PH_LIT: begin
          cmd.op = CMD_LIT;
          ph     = PH_TOP;
        end
        PH_TOK_LO: begin
          token_low_next = b;
          ph             = PH_TOK_HI;
        end
        PH_TOK_HI: begin
          cn                = {5'b0, tok[2:0] & TOKEN_COUNT_MASK};
          match_offset_next = long_dist;
          cmd.distance      = long_dist;
          cmd.count         = cn;
          if (cn == 8'd0) begin
            ph = PH_CNT;
          end else begin
            cmd.op = CMD_COPY;
            ph     = PH_TOP;
          end
        end
        PH_CNT: begin
          cn        = b;
          cmd.count = b;
          cmd.op    = (b == 8'd0) ? CMD_END : CMD_COPY;
          ph        = PH_TOP;
        end
        PH_SOFF: begin
          match_offset_next = short_dist;
          cmd.distance      = short_dist;
          cmd.op            = CMD_COPY;
          ph                = PH_TOP;
        end
        default: ph = PH_TOP;
      endcase
    end

    adv              = flag_advance(ph, fw, lf, cn);
    phase_next       = adv.phase;
    flag_word_next   = adv.word;
    bits_left_next   = adv.left;
    match_count_next = adv.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TOP;
      flag_word    <= '0;
      bits_left    <= '0;
      flag_half    <= 1'b0;
      token_low    <= '0;
      match_count  <= '0;
      match_offset <= '0;
    end else if (item_valid && cmd_ready) begin
      phase        <= phase_next;
      flag_word    <= flag_word_next;
      bits_left    <= bits_left_next;
      flag_half    <= flag_half_next;
      token_low    <= token_low_next;
      match_count  <= match_count_next;
      match_offset <= match_offset_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lzfd_engine.sv -----
`default_nettype none

module lzfd_engine
  import lzfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_ready,
  output logic      res_valid,
  input  wire logic res_ready,
  output result_t   res
);

  eng_state_t        state, state_next;
  logic              stopped, stopped_next;
  logic [ADDR_W-1:0] wp, wp_next;
  logic [PROD_W-1:0] produced, produced_next;
  logic [ADDR_W-1:0] rp, rp_next;
  logic [LEN_W-1:0]  issue_left, issue_left_next;
  logic [FILL_W-1:0] burst, burst_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [63:0]       pack, pack_next;
  status_t           status, status_next;
  logic              rd_pending, rd_pending_next;
  logic              res_valid_next;
  logic              res_load;
  result_t           res_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [PROD_W-1:0] produced_inc;
  logic              issue;

  lzfd_hist_ram u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  assign produced_inc = (produced < PROD_W'(WINDOW_DEPTH)) ? produced + 1'b1 : produced;
  assign issue = (burst < FILL_W'(PACK_BYTES)) && (issue_left != '0);

  always_comb begin
    state_next      = state;
    stopped_next    = stopped;
    wp_next         = wp;
    produced_next   = produced;
    rp_next         = rp;
    issue_left_next = issue_left;
    burst_next      = burst;
    fill_next       = fill;
    pack_next       = pack;
    status_next     = status;
    rd_pending_next = 1'b0;
    cmd_ready       = 1'b0;
    res_load        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = wp;
    ram_wdata       = cmd.data;
    res_next.out_bytes  = pack;
    res_next.byte_count = 4'(fill);
    res_next.run_last   = (issue_left == '0);
    res_next.status     = status;

    case (state)
      ENG_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (cmd.op)
            CMD_RESTART: begin
              stopped_next  = 1'b0;
              wp_next       = '0;
              produced_next = '0;
            end
            CMD_LIT: begin
              if (!stopped) begin
                ram_we          = 1'b1;
                wp_next         = wp + 1'b1;
                produced_next   = produced_inc;
                pack_next       = {56'b0, cmd.data};
                fill_next       = FILL_W'(1);
                status_next     = ST_DATA;
                issue_left_next = '0;
                state_next      = ENG_EMIT;
              end
            end
            CMD_END: begin
              if (!stopped) begin
                stopped_next    = 1'b1;
                pack_next       = '0;
                fill_next       = '0;
                status_next     = ST_END;
                issue_left_next = '0;
                state_next      = ENG_EMIT;
              end
            end
            CMD_COPY: begin
              if (!stopped) begin
                pack_next = '0;
                fill_next = '0;
                if (PROD_W'(cmd.distance) > produced) begin
                  stopped_next    = 1'b1;
                  status_next     = ST_FAR;
                  issue_left_next = '0;
                  state_next      = ENG_EMIT;
                end else begin
                  status_next     = ST_DATA;
                  issue_left_next = LEN_W'(cmd.count) + LEN_W'(2);
                  rp_next         = wp - cmd.distance[ADDR_W-1:0];
                  burst_next      = '0;
                  state_next      = ENG_COPY;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ENG_COPY: begin
        if (issue) begin
          rp_next         = rp + 1'b1;
          burst_next      = burst + 1'b1;
          issue_left_next = issue_left - 1'b1;
        end
        rd_pending_next = issue;
        if (rd_pending) begin
          ram_we        = 1'b1;
          ram_wdata     = ram_rdata;
          wp_next       = wp + 1'b1;
          produced_next = produced_inc;
          pack_next[{fill[PACK_IDX_W-1:0], 3'b000} +: 8] = ram_rdata;
          fill_next     = fill + 1'b1;
          if (!issue) begin
            state_next = ENG_EMIT;
          end
        end
      end

      ENG_EMIT: begin
        if (!res_valid || res_ready) begin
          res_load = 1'b1;
          if (issue_left == '0) begin
            state_next = ENG_IDLE;
          end else begin
            burst_next = '0;
            fill_next  = '0;
            pack_next  = '0;
            state_next = ENG_COPY;
          end
        end
      end

      default: state_next = ENG_IDLE;
    endcase

    if (res_load) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ENG_IDLE;
      stopped    <= 1'b0;
      wp         <= '0;
      produced   <= '0;
      rd_pending <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      stopped    <= stopped_next;
      wp         <= wp_next;
      produced   <= produced_next;
      rd_pending <= rd_pending_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rp         <= rp_next;
    issue_left <= issue_left_next;
    burst      <= burst_next;
    fill       <= fill_next;
    pack       <= pack_next;
    status     <= status_next;
    if (res_load) begin
      res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_when_stopped: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !ram_we)
    else $error("history written while stopped");

  a_produced_saturates: assert property (@(posedge clk) disable iff (rst)
    produced <= PROD_W'(WINDOW_DEPTH))
    else $error("bytes produced beyond the window");

  a_marker_is_empty: assert property (@(posedge clk) disable iff (rst)
    res_load && (res_next.status != ST_DATA) |-> res_next.byte_count == 4'd0)
    else $error("end or error beat carries data");

  a_data_not_empty: assert property (@(posedge clk) disable iff (rst)
    res_load && (res_next.status == ST_DATA) |-> res_next.byte_count != 4'd0)
    else $error("data beat with no bytes");
`endif

endmodule

`default_nettype wire

// ----- hdl/lz_flagword_decompressor.sv -----
// Flag-word LZ decompressor, fed one compressed byte per input beat.
// Input channel (item_valid / item_ready / item): kind 0 carries a stream
// byte, kind 1 restarts the block for a new stream and gives no result.
// Output channel (res_valid / res_ready / res): each beat carries up to eight
// decompressed bytes, first byte in the low bits, with byte_count, a status
// code and run_last marking the final beat caused by one input beat.
// Flag bytes and the first token byte give no beat; the byte that completes
// a literal, a match or an end marker hands the engine a command. A literal
// is written to the history and its beat is loaded into the output register
// in the emit state; no new input beat is taken until that load. A match of
// L bytes reads the 8 KiB single-write-port history once per byte; each pack
// of up to eight bytes is read, written back to the history and packed, then
// loaded into the output register. End-marker and far-distance errors give
// one empty beat and then the block ignores stream bytes until a restart.
// Reset clears the parser, the engine state, write pointer and produced count;
// the history is never cleared, as every read is checked against that count.
// When the receiver stalls, the finished beat holds in the output register and
// the block keeps taking input that produces no beat; work that has another
// beat to deliver waits until the register is freed.
`default_nettype none

module lz_flagword_decompressor
  import lzfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_ready,
  input  wire item_t item,
  output logic       res_valid,
  input  wire logic  res_ready,
  output result_t    res
);

  cmd_t cmd;
  logic cmd_ready;

  // The parser turns each stream byte into at most one command for the engine.
  lzfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // The engine owns the history memory, the copy loop and the output register.
  lzfd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (item_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // A beat is taken exactly when the engine can take its command.
  assign item_ready = cmd_ready;

endmodule

`default_nettype wire
